### src/bsf_pkg.sv
package bsf_pkg;

  // frame buffer geometry
  localparam int BUF_WIDTH  = 128;
  localparam int BUF_HEIGHT = 128;
  localparam int STRIDE     = BUF_WIDTH * 3;
  localparam int TOTAL      = STRIDE * BUF_HEIGHT;

  // internal widths derived from the geometry
  localparam int WP_W  = $clog2(TOTAL + 1);
  localparam int COL_W = $clog2(STRIDE);
  localparam int ROW_W = $clog2(BUF_HEIGHT + 1);
  localparam int WCL_W = $clog2(BUF_WIDTH + 1);
  localparam int W3_W  = $clog2(STRIDE + 1);

  // port widths
  localparam int ADDR_W = 16;
  localparam int DATA_W = 8;

  // file format constants
  localparam logic [7:0]  SIG_B   = 8'h42;
  localparam logic [7:0]  SIG_M   = 8'h4D;
  localparam logic [31:0] HDR_LEN = 32'd40;

  // result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // result kinds
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_FILL  = 1'b1;

  // one result word
  typedef struct packed {
    logic              op_kind;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] end_address;
    logic [DATA_W-1:0] data;
    logic              last;
  } res_t;

  // everything one input byte produces
  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } step_t;

endpackage

### src/bmp_stream_to_framebuffer.sv
// channel | direction | word                                    | handshake
// in      | input     | byte_in                                 | in_valid / in_stall
// out     | output    | op_kind, address, end_address, data, last | out_valid / out_stall
//
// one file byte is accepted per cycle while in_stall is low; its results enter the
// queue when the input register hands it to the parser, and are offered at the output
// from then on; a byte can cause two result words, and the four-word queue absorbs
// them, so the output port sets the long-run rate
// rst is synchronous and returns the parser to signature hunt with an empty queue
// out_stall fills the queue, then holds the input register and raises in_stall
module bmp_stream_to_framebuffer import bsf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        byte_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              op_kind,
  output logic [ADDR_W-1:0] address,
  output logic [ADDR_W-1:0] end_address,
  output logic [DATA_W-1:0] data,
  output logic              last
);

  logic        in_reg_valid;
  logic [7:0]  byte_reg;
  logic        consume;
  logic        room;
  logic        pop;
  step_t       step;
  res_t        head;

  // input register
  assign consume  = in_reg_valid && room;
  assign in_stall = in_reg_valid && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_reg_valid <= 1'b1;
    end else if (consume) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_reg <= byte_in;
    end
  end

  // header parse and pixel placement
  bsf_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .go      (consume),
    .byte_in (byte_reg),
    .step    (step)
  );

  // result queue
  assign pop = out_valid && !out_stall;

  bsf_res_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .pop       (pop),
    .head      (head),
    .not_empty (out_valid),
    .room      (room)
  );

  assign op_kind     = head.op_kind;
  assign address     = head.address;
  assign end_address = head.end_address;
  assign data        = head.data;
  assign last        = head.last;

`ifndef SYNTHESIS
  a_in_reg_loaded: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_reg_valid)
    else $error("accepted byte not held in input register");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    !consume |-> (step.count == 2'd0))
    else $error("result produced without a byte being consumed");

  a_last_single: assert property (@(posedge clk) disable iff (rst)
    (step.count == 2'd1) |-> step.r0.last)
    else $error("single result lacks last flag");

  a_last_pair: assert property (@(posedge clk) disable iff (rst)
    (step.count == 2'd2) |-> (step.r1.last && !step.r0.last))
    else $error("last flag misplaced on result pair");
`endif

endmodule

### src/bsf_parse.sv
module bsf_parse import bsf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [7:0]  byte_in,
  output step_t       step
);

  // parser phases
  typedef enum logic [12:0] {
    PH_IDLE     = 13'b0000000000001,
    PH_SIG2     = 13'b0000000000010,
    PH_SIZE     = 13'b0000000000100,
    PH_RESERVED = 13'b0000000001000,
    PH_START    = 13'b0000000010000,
    PH_HDRLEN   = 13'b0000000100000,
    PH_WIDTH    = 13'b0000001000000,
    PH_HEIGHT   = 13'b0000010000000,
    PH_PLANES   = 13'b0000100000000,
    PH_BPP      = 13'b0001000000000,
    PH_SEEK     = 13'b0010000000000,
    PH_PIXELS   = 13'b0100000000000,
    PH_DRAIN    = 13'b1000000000000
  } phase_t;

  phase_t            phase, phase_next;
  logic [1:0]        fbc, fbc_next;
  logic [31:0]       file_size, file_size_next;
  logic [31:0]       pixel_start, pixel_start_next;
  logic [31:0]       header_length, header_length_next;
  logic [31:0]       image_width, image_width_next;
  logic [31:0]       image_height, image_height_next;
  logic [31:0]       byte_offset, byte_offset_next;
  logic [WP_W-1:0]   wp, wp_next;
  logic [ROW_W-1:0]  row, row_next;
  logic [COL_W-1:0]  col, col_next;

  logic [WCL_W-1:0]  w_cl;
  logic [W3_W-1:0]   w3;
  logic [ROW_W-1:0]  h_cl;
  logic              eof;
  logic [WP_W-1:0]   wp_inc;
  logic [WP_W-1:0]   rs;
  logic              rs_in;
  logic              col_wrap;
  res_t              r0, r1;
  logic [1:0]        n;

  // replace one byte of a little-endian field
  function automatic logic [31:0] set_byte(input logic [31:0] v, input logic [1:0] k,
                                           input logic [7:0] b);
    logic [31:0] r;
    r = v;
    unique case (k)
      2'd0: r[7:0]   = b;
      2'd1: r[15:8]  = b;
      2'd2: r[23:16] = b;
      2'd3: r[31:24] = b;
      default: r = v;
    endcase
    return r;
  endfunction

  function automatic res_t mk_write(input logic [WP_W-1:0] a, input logic [7:0] d);
    res_t r;
    r.op_kind     = OP_WRITE;
    r.address     = ADDR_W'(a);
    r.end_address = '0;
    r.data        = d;
    r.last        = 1'b0;
    return r;
  endfunction

  function automatic res_t mk_fill(input logic [WP_W-1:0] a, input logic [WP_W-1:0] e);
    res_t r;
    r.op_kind     = OP_FILL;
    r.address     = ADDR_W'(a);
    r.end_address = ADDR_W'(e);
    r.data        = '0;
    r.last        = 1'b0;
    return r;
  endfunction

  // clamped image size and row geometry
  assign w_cl     = (image_width < 32'(BUF_WIDTH)) ? WCL_W'(image_width) : WCL_W'(BUF_WIDTH);
  assign w3       = W3_W'(w_cl) + (W3_W'(w_cl) << 1);
  assign h_cl     = (image_height < 32'(BUF_HEIGHT)) ? ROW_W'(image_height)
                                                      : ROW_W'(BUF_HEIGHT);
  assign eof      = ({1'b0, byte_offset} + 33'd1) >= {1'b0, file_size};
  assign wp_inc   = wp + WP_W'(1);
  assign rs       = (col != '0) ? (wp + WP_W'(STRIDE) - WP_W'(col)) : wp;
  assign rs_in    = (col == '0) || (row != ROW_W'(BUF_HEIGHT - 1));
  assign col_wrap = (col == COL_W'(STRIDE - 1));

  // next state and results for the byte in the input register
  always_comb begin
    phase_next         = phase;
    fbc_next           = fbc;
    file_size_next     = file_size;
    pixel_start_next   = pixel_start;
    header_length_next = header_length;
    image_width_next   = image_width;
    image_height_next  = image_height;
    byte_offset_next   = byte_offset + 32'd1;
    wp_next            = wp;
    row_next           = row;
    col_next           = col;
    r0                 = '0;
    r1                 = '0;
    n                  = 2'd0;

    unique case (phase)
      PH_IDLE: begin
        if (byte_in == SIG_B) begin
          phase_next = PH_SIG2;
        end
        fbc_next         = 2'd0;
        byte_offset_next = 32'd1;
      end
      PH_SIG2: begin
        phase_next = (byte_in == SIG_M) ? PH_SIZE : PH_IDLE;
        fbc_next   = 2'd0;
      end
      PH_SIZE: begin
        file_size_next = set_byte(file_size, fbc, byte_in);
        fbc_next       = fbc + 2'd1;
        if (fbc == 2'd3) begin
          phase_next = PH_RESERVED;
        end
      end
      PH_RESERVED: begin
        fbc_next = fbc + 2'd1;
        if (fbc == 2'd3) begin
          phase_next = PH_START;
        end
      end
      PH_START: begin
        pixel_start_next = set_byte(pixel_start, fbc, byte_in);
        fbc_next         = fbc + 2'd1;
        if (fbc == 2'd3) begin
          phase_next = PH_HDRLEN;
        end
      end
      PH_HDRLEN: begin
        header_length_next = set_byte(header_length, fbc, byte_in);
        fbc_next           = fbc + 2'd1;
        if (fbc == 2'd3) begin
          phase_next = (header_length_next == HDR_LEN) ? PH_WIDTH : PH_IDLE;
        end
      end
      PH_WIDTH: begin
        image_width_next = set_byte(image_width, fbc, byte_in);
        fbc_next         = fbc + 2'd1;
        if (fbc == 2'd3) begin
          phase_next = PH_HEIGHT;
        end
      end
      PH_HEIGHT: begin
        image_height_next = set_byte(image_height, fbc, byte_in);
        fbc_next          = fbc + 2'd1;
        if (fbc == 2'd3) begin
          phase_next = PH_PLANES;
        end
      end
      PH_PLANES: begin
        if (fbc != 2'd0) begin
          fbc_next   = 2'd0;
          phase_next = PH_BPP;
        end else begin
          fbc_next = fbc + 2'd1;
        end
      end
      PH_BPP: begin
        fbc_next = fbc + 2'd1;
        if (fbc == 2'd3) begin
          phase_next = PH_SEEK;
        end
      end
      PH_SEEK: begin
        // first pixel byte lands at address zero
        if (byte_offset == pixel_start) begin
          phase_next = PH_PIXELS;
          r0         = mk_write('0, byte_in);
          n          = 2'd1;
          wp_next    = WP_W'(1);
          row_next   = '0;
          col_next   = COL_W'(1);
        end
      end
      PH_PIXELS: begin
        if (row < h_cl) begin
          if ((W3_W'(col) < w3) || (col[1:0] != 2'd0)) begin
            // pixel or padding byte
            r0       = mk_write(wp, byte_in);
            n        = 2'd1;
            wp_next  = wp_inc;
            row_next = col_wrap ? row + ROW_W'(1) : row;
            col_next = col_wrap ? '0 : col + COL_W'(1);
            if (eof) begin
              phase_next = PH_IDLE;
              if (wp_inc < WP_W'(TOTAL)) begin
                r1 = mk_fill(wp_inc, WP_W'(TOTAL));
                n  = 2'd2;
              end
              wp_next  = WP_W'(TOTAL);
              row_next = ROW_W'(BUF_HEIGHT);
              col_next = '0;
            end
          end else if (eof) begin
            // row end meets end of file
            r0 = mk_fill(wp, WP_W'(TOTAL));
            n  = 2'd1;
            if (rs_in) begin
              r1 = mk_write(rs, byte_in);
              n  = 2'd2;
            end
            phase_next = PH_IDLE;
            wp_next    = WP_W'(TOTAL);
            row_next   = ROW_W'(BUF_HEIGHT);
            col_next   = '0;
          end else if (col != '0) begin
            // clear the rest of the row, byte opens the next row
            r0 = mk_fill(wp, rs);
            n  = 2'd1;
            if (rs_in) begin
              r1       = mk_write(rs, byte_in);
              n        = 2'd2;
              wp_next  = rs + WP_W'(1);
              row_next = row + ROW_W'(1);
              col_next = COL_W'(1);
            end else begin
              wp_next  = WP_W'(TOTAL);
              row_next = ROW_W'(BUF_HEIGHT);
              col_next = '0;
            end
          end else begin
            // zero-width row: byte goes to the row start
            r0       = mk_write(wp, byte_in);
            n        = 2'd1;
            wp_next  = wp_inc;
            col_next = COL_W'(1);
          end
        end else begin
          // image complete: clear the rest of the buffer
          if (wp < WP_W'(TOTAL)) begin
            r0 = mk_fill(wp, WP_W'(TOTAL));
            n  = 2'd1;
          end
          wp_next    = WP_W'(TOTAL);
          row_next   = ROW_W'(BUF_HEIGHT);
          col_next   = '0;
          phase_next = eof ? PH_IDLE : PH_DRAIN;
        end
      end
      PH_DRAIN: begin
        if (eof) begin
          phase_next = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    // mark the final result of this byte
    if (n == 2'd1) begin
      r0.last = 1'b1;
    end else if (n == 2'd2) begin
      r1.last = 1'b1;
    end
  end

  assign step.count = go ? n : 2'd0;
  assign step.r0    = r0;
  assign step.r1    = r1;

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      fbc           <= 2'd0;
      file_size     <= '0;
      pixel_start   <= '0;
      header_length <= '0;
      image_width   <= '0;
      image_height  <= '0;
      byte_offset   <= '0;
      wp            <= '0;
      row           <= '0;
      col           <= '0;
    end else if (go) begin
      phase         <= phase_next;
      fbc           <= fbc_next;
      file_size     <= file_size_next;
      pixel_start   <= pixel_start_next;
      header_length <= header_length_next;
      image_width   <= image_width_next;
      image_height  <= image_height_next;
      byte_offset   <= byte_offset_next;
      wp            <= wp_next;
      row           <= row_next;
      col           <= col_next;
    end
  end

endmodule

### src/bsf_res_fifo.sv
module bsf_res_fifo import bsf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  step_t push,
  input  logic  pop,
  output res_t  head,
  output logic  not_empty,
  output logic  room
);

  res_t               q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] count;

  // store up to two result words per cycle
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      q[wr_ptr] <= push.r0;
    end
    if (push.count == 2'd2) begin
      q[wr_ptr + FIFO_AW'(1)] <= push.r1;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(push.count);
      rd_ptr <= rd_ptr + FIFO_AW'(pop);
      count  <= count + FIFO_CW'(push.count) - FIFO_CW'(pop);
    end
  end

  assign head      = q[rd_ptr];
  assign not_empty = (count != '0);
  assign room      = (count <= FIFO_CW'(FIFO_DEPTH - 2));

endmodule

### bench/tb_bmp_stream_to_framebuffer.sv
import bsf_pkg::*;

// parser position inside a file
typedef enum logic [3:0] {
  S_HUNT, S_SIG_M, S_FSIZE, S_RSVD, S_OFFSET, S_HDRLEN, S_WIDTH,
  S_HEIGHT, S_PLANES, S_BPP, S_SEEK, S_PIXELS, S_DRAIN
} parse_state_t;

// tracks the decoder and the frame buffer operations still due
class framebuffer_ops_t;
  parse_state_t phase = S_HUNT;
  bit [1:0]  fcount = '0;
  bit [31:0] fsize = '0;
  bit [31:0] pstart = '0;
  bit [31:0] hdr_len = '0;
  bit [31:0] img_w = '0;
  bit [31:0] img_h = '0;
  bit [31:0] offs = '0;
  bit [31:0] wptr = '0;

  res_t step_ops[$];
  res_t due_ops[$];
  int unsigned checked = 0;
  int unsigned writes = 0;
  int unsigned fills = 0;
  int unsigned fails = 0;

  function int pending();
    return due_ops.size();
  endfunction

  // little-endian field byte, true on the fourth
  function bit field_done();
    bit [1:0] k;
    k = fcount;
    fcount = k + 2'd1;
    return k == 2'd3;
  endfunction

  // count through a skipped field of n bytes
  function bit skip_done(int n);
    int k;
    k = fcount;
    fcount = fcount + 2'd1;
    if (k + 1 >= n) begin
      fcount = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function void add_op(logic kind, bit [31:0] addr, bit [31:0] stop, bit [7:0] val);
    res_t r;
    r.op_kind = kind;
    r.address = addr[ADDR_W-1:0];
    r.end_address = stop[ADDR_W-1:0];
    r.data = val;
    r.last = 1'b0;
    step_ops.push_back(r);
  endfunction

  // one accepted file byte
  function void take_byte(logic [7:0] b);
    bit [31:0] w, h, wp, row, col, rs;
    bit eof, ended;
    step_ops.delete();
    ended = 1'b0;
    eof = ({1'b0, offs} + 33'd1) >= {1'b0, fsize};
    case (phase)
      S_HUNT: begin
        if (b == SIG_B) phase = S_SIG_M;
        fcount = '0;
        offs = '0;
      end
      S_SIG_M: begin
        phase = (b == SIG_M) ? S_FSIZE : S_HUNT;
        fcount = '0;
      end
      S_FSIZE: begin
        fsize[8*fcount +: 8] = b;
        if (field_done()) phase = S_RSVD;
      end
      S_RSVD: begin
        if (skip_done(4)) phase = S_OFFSET;
      end
      S_OFFSET: begin
        pstart[8*fcount +: 8] = b;
        if (field_done()) phase = S_HDRLEN;
      end
      S_HDRLEN: begin
        hdr_len[8*fcount +: 8] = b;
        if (field_done()) phase = (hdr_len == HDR_LEN) ? S_WIDTH : S_HUNT;
      end
      S_WIDTH: begin
        img_w[8*fcount +: 8] = b;
        if (field_done()) phase = S_HEIGHT;
      end
      S_HEIGHT: begin
        img_h[8*fcount +: 8] = b;
        if (field_done()) phase = S_PLANES;
      end
      S_PLANES: begin
        if (skip_done(2)) phase = S_BPP;
      end
      S_BPP: begin
        if (skip_done(4)) phase = S_SEEK;
      end
      S_SEEK: begin
        if (offs == pstart) begin
          phase = S_PIXELS;
          add_op(OP_WRITE, 0, 0, b);
          wptr = 1;
        end
      end
      S_PIXELS: begin
        w = (img_w < BUF_WIDTH) ? img_w : BUF_WIDTH;
        h = (img_h < BUF_HEIGHT) ? img_h : BUF_HEIGHT;
        wp = (wptr < TOTAL) ? wptr : TOTAL;
        row = wp / STRIDE;
        col = wp % STRIDE;
        if (row < h) begin
          if (col < w * 3 || col[1:0] != 2'd0) begin
            // pixel or padding byte
            add_op(OP_WRITE, wp, 0, b);
            wp = wp + 1;
          end else begin
            // row done, clear its tail and start the next row
            rs = wp + ((col != 0) ? STRIDE - col : 0);
            if (eof) begin
              add_op(OP_FILL, wp, TOTAL, 0);
              if (rs < TOTAL) add_op(OP_WRITE, rs, 0, b);
              wptr = TOTAL;
              phase = S_HUNT;
              ended = 1'b1;
            end else begin
              if (rs != wp) add_op(OP_FILL, wp, rs, 0);
              if (rs < TOTAL) begin
                add_op(OP_WRITE, rs, 0, b);
                wp = rs + 1;
              end else begin
                wp = TOTAL;
              end
            end
          end
        end else begin
          // image complete, clear the rest and wait for end of file
          if (wp < TOTAL) add_op(OP_FILL, wp, TOTAL, 0);
          wp = TOTAL;
          phase = S_DRAIN;
        end
        if (!ended) begin
          if (eof) begin
            phase = S_HUNT;
            if (wp < TOTAL) add_op(OP_FILL, wp, TOTAL, 0);
            wp = TOTAL;
          end
          wptr = wp;
        end
      end
      S_DRAIN: begin
        if (eof) phase = S_HUNT;
      end
      default: phase = S_HUNT;
    endcase
    offs = offs + 1;
    if (step_ops.size() > 0) step_ops[step_ops.size()-1].last = 1'b1;
    foreach (step_ops[i]) due_ops.push_back(step_ops[i]);
  endfunction

  // one accepted result word against the oldest one due
  function void match_op(res_t got);
    res_t want;
    checked++;
    if (due_ops.size() == 0) begin
      $error("unexpected result: op_kind %0d address %0d end_address %0d data %0d",
             got.op_kind, got.address, got.end_address, got.data);
      fails++;
      return;
    end
    want = due_ops.pop_front();
    if (want.op_kind == OP_FILL) fills++;
    else writes++;
    if (got.op_kind !== want.op_kind) begin
      $error("op_kind: expected %0d, got %0d", want.op_kind, got.op_kind);
      fails++;
    end
    if (got.address !== want.address) begin
      $error("address: expected %0d, got %0d", want.address, got.address);
      fails++;
    end
    if (got.end_address !== want.end_address) begin
      $error("end_address: expected %0d, got %0d", want.end_address, got.end_address);
      fails++;
    end
    if (got.data !== want.data) begin
      $error("data: expected %0d, got %0d", want.data, got.data);
      fails++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, got.last);
      fails++;
    end
  endfunction
endclass

module tb_bmp_stream_to_framebuffer;
  timeunit 1ns;
  timeprecision 1ps;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        byte_in = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              op_kind;
  logic [ADDR_W-1:0] address;
  logic [ADDR_W-1:0] end_address;
  logic [DATA_W-1:0] data;
  logic              last;

  framebuffer_ops_t fb_ops = new;
  res_t             got_op;

  int burst_left = 0;
  int bytes_sent = 0;
  int files_sent = 0;
  int odd_files = 0;
  int pauses = 0;

  bmp_stream_to_framebuffer u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .byte_in(byte_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .op_kind(op_kind),
    .address(address),
    .end_address(end_address),
    .data(data),
    .last(last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watch both handshakes
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) fb_ops.take_byte(byte_in);
      if (out_valid && !out_stall) begin
        got_op.op_kind = op_kind;
        got_op.address = address;
        got_op.end_address = end_address;
        got_op.data = data;
        got_op.last = last;
        fb_ops.match_op(got_op);
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  int       stall_mode = 0;
  int       mode_left = 0;
  int       hold_left = 0;
  bit       held = 1'b0;
  bit [7:0] stall_mask = 8'h00;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!held && fb_ops.checked >= 150) begin
      held <= 1'b1;
      hold_left <= 299;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(10, 120);
        stall_mask <= 8'($urandom);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 1) == 1);
        2: out_stall <= ($urandom_range(0, 4) != 0);
        default: begin
          out_stall <= stall_mask[0];
          if (mode_left != 0) stall_mask <= {stall_mask[0], stall_mask[7:1]};
        end
      endcase
    end
  end

  // offer one byte, in bursts with gaps between them
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    byte_in <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  // hold the input until every result due has come
  task automatic pause_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (fb_ops.pending() > 0) @(posedge clk);
    pauses++;
  endtask

  // build and send one file: header, filler up to the pixel offset, padded rows
  task automatic send_file(input bit [31:0] hlen, input bit [31:0] w, input bit [31:0] h,
                           input int rows, input int pix_at, input int size_adj);
    bit [7:0]  fbytes[$];
    bit [31:0] hw[6];
    bit [31:0] fsize;
    int wc, row_bytes, filler, total_len, limit;
    wc = (w > 128) ? 128 : w;
    row_bytes = ((wc * 3 + 3) / 4) * 4;
    filler = (pix_at > 32) ? pix_at - 32 : 0;
    total_len = 32 + filler + rows * row_bytes + size_adj;
    fsize = (total_len > 0) ? total_len : 0;
    hw = '{fsize, $urandom, pix_at, hlen, w, h};
    fbytes.push_back(SIG_B);
    fbytes.push_back(SIG_M);
    for (int j = 0; j < 6; j++)
      for (int i = 0; i < 4; i++) fbytes.push_back(hw[j][8*i +: 8]);
    repeat (6 + filler + rows * row_bytes) fbytes.push_back(8'($urandom));
    if (hlen != HDR_LEN) begin
      limit = 18;
    end else if (pix_at < 32) begin
      limit = 52;
    end else begin
      limit = (fsize > pix_at + 2) ? fsize : pix_at + 2;
      limit += $urandom_range(0, 3);
    end
    while (fbytes.size() < limit) fbytes.push_back(8'($urandom));
    for (int i = 0; i < limit; i++) send_byte(fbytes[i]);
    files_sent++;
  endtask

  initial begin
    int pick, hgt, rows, adj;
    bit [31:0] w, hl;
    logic [7:0] b;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: idle noise and a broken signature
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SIG_M);
    send_byte(SIG_B);
    send_byte(SIG_B);
    send_byte(SIG_M);
    // directed: wrong header length, tiny image, image complete before end of file
    send_file(41, 1, 1, 1, 32, 0);
    send_file(40, 1, 1, 1, 32, 0);
    send_file(40, 2, 2, 2, 54, 6);
    // row end on the last byte of the file
    send_file(40, 1, 2, 2, 40, -3);
    // zero file size
    send_file(40, 3, 1, 1, 32, -44);
    // oversized width, top-down height, cut short
    send_file(40, 300, 32'hFFFF_FFFF, 2, 54, -620);
    odd_files += 6;
    pause_for_results();

    // random files, mostly well formed
    while (bytes_sent < 540) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        hgt = $urandom_range(0, 4);
        rows = hgt + int'($urandom_range(0, 2)) - 1;
        if (rows < 0) rows = 0;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: adj = 0;
          6, 7: adj = $urandom_range(1, 8);
          default: adj = -int'($urandom_range(1, 12));
        endcase
        send_file(40, $urandom_range(0, 12), hgt, rows, $urandom_range(32, 70), adj);
      end else if (pick < 75) begin
        hl = $urandom;
        if (hl == HDR_LEN) hl = 41;
        send_file(hl, $urandom_range(0, 12), $urandom_range(0, 4), 1, 54, 0);
        odd_files++;
      end else if (pick < 80) begin
        b = 8'($urandom);
        if (b == SIG_M) b = 8'h00;
        send_byte(SIG_B);
        send_byte(b);
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 10)) send_byte(8'($urandom));
      end else if (pick < 92) begin
        w = ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(100, 400);
        hgt = ($urandom_range(0, 1) == 1) ? $urandom_range(129, 300) : -1;
        send_file(40, w, hgt, 2, 54, -int'($urandom_range(560, 740)));
        odd_files++;
      end else begin
        pause_for_results();
      end
    end

    // pixel offset that lies behind the header, never reached
    send_file(40, 2, 2, 1, $urandom_range(0, 31), 0);
    odd_files++;

    // let everything due come out
    in_valid <= 1'b0;
    while (fb_ops.pending() > 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("run covered %0d files (%0d odd or cut) in %0d bytes, %0d input pauses",
             files_sent, odd_files, bytes_sent, pauses);
    $display("%0d results checked: %0d writes, %0d fills, %0d mismatches",
             fb_ops.checked, fb_ops.writes, fb_ops.fills, fb_ops.fails);
    if (fb_ops.fails == 0) begin
      $display("tb_bmp_stream_to_framebuffer: PASS");
    end else begin
      $display("tb_bmp_stream_to_framebuffer: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(2_000_000);
    $display("tb_bmp_stream_to_framebuffer: FAIL");
    $finish;
  end

endmodule
